FILE: rtl/bsa_pkg.sv
package bsa_pkg;

   // bitmap word geometry
   localparam int WORD_BITS  = 8;
   localparam int WORD_SHIFT = 3;

   // field widths
   localparam int START_W = 8;
   localparam int LEN_W   = 9;
   localparam int FIRST_W = 8;

   // slot positions and word indexes inside the reachable range
   localparam int POS_W   = 10;
   localparam int WIDX_W  = POS_W - WORD_SHIFT;
   localparam int CAP_MAX = (2 ** LEN_W) - 1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ZERO  = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage

FILE: rtl/bsa_ram.sv
module bsa_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bitmap_span_allocator_top.sv
// first-fit span allocator over an occupancy bitmap held in a synchronous ram
//
// request channel (req_valid / req_stall): req_mode 0 acquires req_span_length
// consecutive free slots at the lowest possible start below the capacity;
// req_mode 1 releases req_span_length slots from req_span_start
// result channel (rsp_valid / rsp_stall): rsp_status and rsp_first_slot, one
// result per request, held in an output register while rsp_stall is high
// csr channel (csr_valid / csr_ready): writes the capacity register, always ready
//
// one request is in flight at a time; the bitmap is read one 8-slot word per
// cycle through the single ram read port, then the touched words are
// read-modified-written one per cycle
//   acquire: scans words up to the hit (up to 32 at 256 slots), then marks
//            the words that the span touches; no free span ends after the scan
//   release: clears the touched words; zero count or range error: result without ram access
// the next request is taken once the result sits in the output register
// reset: capacity returns to 256 and a clearing pass writes every bitmap word
// to zero, one word a cycle, with req_stall high
// a stalled result keeps the block from finishing the following request
module bitmap_span_allocator_top #(
   parameter int SLOTS = 256
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [bsa_pkg::START_W-1:0]   req_span_start,
   input  logic [bsa_pkg::LEN_W-1:0]     req_span_length,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bsa_pkg::status_type           rsp_status,
   output logic [bsa_pkg::FIRST_W-1:0]   rsp_first_slot,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bsa_pkg::LEN_W-1:0]     csr_capacity
);

   import bsa_pkg::*;

   localparam int WORDS    = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SLOT_LIM = (SLOTS > CAP_MAX) ? CAP_MAX : SLOTS;

   localparam logic [POS_W-1:0]  SLOT_LIM_P   = POS_W'(SLOT_LIM);
   localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(WORDS - 1);
   localparam logic              MODE_ACQUIRE = 1'b0;

   typedef enum logic [2:0] {
      S_CLR,
      S_IDLE,
      S_SCAN,
      S_UPD,
      S_FIN
   } state_type;

   // control
   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   capacity_ff, capacity_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [WIDX_W-1:0]  rd_idx_ff, rd_idx_in;       // next word to read
   logic [WIDX_W-1:0]  proc_idx_ff, proc_idx_in;   // word on the ram output
   logic               pend_ff, pend_in;           // ram output holds proc word
   logic               rsp_valid_ff, rsp_valid_in;

   // per-request working values
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   run_ff, run_in;             // free run entering the word
   logic [POS_W-1:0]   lo_ff, lo_in;
   logic [POS_W-1:0]   hi_ff, hi_in;
   logic [WIDX_W-1:0]  last_idx_ff, last_idx_in;
   logic               set_ff, set_in;
   status_type         res_status_ff, res_status_in;
   logic [POS_W-1:0]   res_first_ff, res_first_in;

   // output register
   status_type         rsp_status_ff, rsp_status_in;
   logic [FIRST_W-1:0] rsp_first_ff, rsp_first_in;

   // ram port
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   // datapath
   logic [POS_W-1:0]     cap_eff;
   logic                 req_acc;
   logic [POS_W-1:0]     rel_end;
   logic                 scan_found;
   logic [LEN_W-1:0]     scan_run;
   logic [POS_W-1:0]     scan_first;
   logic [POS_W-1:0]     scan_end;
   logic                 word_last;
   logic                 issue_ok;
   logic [WORD_BITS-1:0] upd_word;

   bsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // capacity above the built slot count acts as the slot count
   assign cap_eff = ({1'b0, capacity_ff} > SLOT_LIM_P) ? SLOT_LIM_P : POS_W'(capacity_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rel_end   = POS_W'(req_span_start) + POS_W'(req_span_length);

   // first-fit scan of one bitmap word; slots at or above capacity count as used
   always_comb begin
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] hit_pos;
      logic [POS_W-1:0] word_top;
      logic [LEN_W-1:0] run;
      logic             found;
      run     = run_ff;
      found   = 1'b0;
      hit_pos = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         pos = {proc_idx_ff, WORD_SHIFT'(b)};
         if (!found) begin
            if (ram_rd_data[b] || (pos >= cap_eff)) begin
               run = '0;
            end else begin
               run = LEN_W'(run + 1'b1);
               if (run == len_ff) begin
                  found   = 1'b1;
                  hit_pos = pos;
               end
            end
         end
      end
      word_top   = {proc_idx_ff, {WORD_SHIFT{1'b1}}};
      scan_found = found;
      scan_run   = run;
      scan_first = POS_W'(hit_pos + 1'b1 - POS_W'(len_ff));
      scan_end   = POS_W'(scan_first + POS_W'(len_ff));
      word_last  = POS_W'(word_top + 1'b1) >= cap_eff;
      issue_ok   = {rd_idx_ff, {WORD_SHIFT{1'b0}}} < cap_eff;
   end

   // set or clear the part of the word inside [lo, hi)
   always_comb begin
      logic [POS_W-1:0] pos;
      for (int b = 0; b < WORD_BITS; b++) begin
         pos = {proc_idx_ff, WORD_SHIFT'(b)};
         upd_word[b] = ((pos >= lo_ff) && (pos < hi_ff)) ? set_ff : ram_rd_data[b];
      end
   end

   always_comb begin
      logic [POS_W-1:0] hi_m1;
      hi_m1         = '0;
      state_in      = state_ff;
      capacity_in   = capacity_ff;
      clr_addr_in   = clr_addr_ff;
      rd_idx_in     = rd_idx_ff;
      proc_idx_in   = proc_idx_ff;
      pend_in       = pend_ff;
      len_in        = len_ff;
      run_in        = run_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      last_idx_in   = last_idx_ff;
      set_in        = set_ff;
      res_status_in = res_status_ff;
      res_first_in  = res_first_ff;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      ram_wr_en   = 1'b0;
      ram_wr_addr = ADDR_W'(proc_idx_ff);
      ram_wr_data = upd_word;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ADDR_W'(rd_idx_ff);

      if (csr_valid && csr_ready) begin
         capacity_in = csr_capacity;
      end

      unique case (state_ff)
         S_CLR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = ADDR_W'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_acc) begin
               len_in       = req_span_length;
               rd_idx_in    = '0;
               pend_in      = 1'b0;
               run_in       = '0;
               res_first_in = '0;
               if (req_mode == MODE_ACQUIRE) begin
                  if (req_span_length == '0) begin
                     res_status_in = ST_ZERO;
                     state_in      = S_FIN;
                  end else if (cap_eff == '0) begin
                     res_status_in = ST_FULL;
                     state_in      = S_FIN;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  if (rel_end > cap_eff) begin
                     res_status_in = ST_RANGE;
                     state_in      = S_FIN;
                  end else begin
                     res_status_in = ST_OK;
                     if (req_span_length == '0) begin
                        state_in = S_FIN;
                     end else begin
                        hi_m1       = POS_W'(rel_end - 1'b1);
                        lo_in       = POS_W'(req_span_start);
                        hi_in       = rel_end;
                        set_in      = 1'b0;
                        last_idx_in = hi_m1[POS_W-1:WORD_SHIFT];
                        rd_idx_in   = lo_in[POS_W-1:WORD_SHIFT];
                        state_in    = S_UPD;
                     end
                  end
               end
            end
         end

         S_SCAN: begin
            if (pend_ff && scan_found) begin
               // hit: mark the span, starting from the word that holds its start
               hi_m1         = POS_W'(scan_end - 1'b1);
               res_status_in = ST_OK;
               res_first_in  = scan_first;
               lo_in         = scan_first;
               hi_in         = scan_end;
               set_in        = 1'b1;
               last_idx_in   = hi_m1[POS_W-1:WORD_SHIFT];
               rd_idx_in     = scan_first[POS_W-1:WORD_SHIFT];
               pend_in       = 1'b0;
               state_in      = S_UPD;
            end else if (pend_ff && word_last) begin
               res_status_in = ST_FULL;
               res_first_in  = '0;
               pend_in       = 1'b0;
               state_in      = S_FIN;
            end else begin
               if (pend_ff) begin
                  run_in = scan_run;
               end
               // keep one word read ahead of the word being scanned
               if (issue_ok) begin
                  ram_rd_en   = 1'b1;
                  pend_in     = 1'b1;
                  proc_idx_in = rd_idx_ff;
                  rd_idx_in   = WIDX_W'(rd_idx_ff + 1'b1);
               end else begin
                  pend_in = 1'b0;
               end
            end
         end

         S_UPD: begin
            // write word k while reading word k+1, never the same entry
            if (pend_ff) begin
               ram_wr_en = 1'b1;
            end
            if (pend_ff && (proc_idx_ff == last_idx_ff)) begin
               pend_in  = 1'b0;
               state_in = S_FIN;
            end else if (rd_idx_ff <= last_idx_ff) begin
               ram_rd_en   = 1'b1;
               pend_in     = 1'b1;
               proc_idx_in = rd_idx_ff;
               rd_idx_in   = WIDX_W'(rd_idx_ff + 1'b1);
            end else begin
               pend_in = 1'b0;
            end
         end

         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_first_in  = res_first_ff[FIRST_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         capacity_ff  <= LEN_W'(256);
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff     <= rd_idx_in;
      proc_idx_ff   <= proc_idx_in;
      len_ff        <= len_in;
      run_ff        <= run_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      last_idx_ff   <= last_idx_in;
      set_ff        <= set_in;
      res_status_ff <= res_status_in;
      res_first_ff  <= res_first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_first_slot = rsp_first_ff;

endmodule

FILE: rtl/bsa_checker.sv
module bsa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input bsa_pkg::status_type         rsp_status,
   input logic [bsa_pkg::FIRST_W-1:0] rsp_first_slot
);

   import bsa_pkg::*;

   // no result shows right after reset
   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the clearing pass holds off requests right after reset
   a_clear_stall : assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during bitmap clear");

   // one request at a time: an accepted request blocks the next cycle
   a_one_inflight : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted back to back");

   // only a granted acquire carries a start slot
   a_first_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_first_slot == '0))
      else $error("nonzero start slot on failed request");

   // a stalled result holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_first_slot)))
      else $error("stalled result changed");

endmodule

bind bitmap_span_allocator_top bsa_checker u_bsa_checker (.*);
